@@ rtl/pwg_pkg.sv @@
`timescale 1ns / 1ps

package pwg_pkg;

   // fixed field widths
   localparam int CFG_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int MODE_W     = 2;
   localparam int SAMPLE_W   = 17;
   localparam int TERM_W     = 17;
   localparam int DIV_W      = 16;
   localparam int DIV_CNT_W  = 5;

   // parameter defaults
   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int SAMPLE_BITS_DEF     = 16;

   // register reset values
   localparam logic [CFG_W-1:0] PERIOD_RST = 16'd100;
   localparam logic [CFG_W-1:0] DELAY_RST  = 16'd0;
   localparam logic [CFG_W-1:0] OFFSET_RST = 16'd0;
   localparam logic [CFG_W-1:0] AMP_RST    = 16'd0;
   localparam logic [CFG_W-1:0] DUTY_RST   = 16'd50;
   localparam logic [CFG_W-1:0] PHASE_RST  = 16'd0;
   localparam logic [CFG_W-1:0] DECAY_RST  = 16'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PERIOD,
      CSR_DELAY,
      CSR_OFFSET,
      CSR_AMPLITUDE,
      CSR_DUTY,
      CSR_PHASE,
      CSR_MODE,
      CSR_DECAY
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      WAVE_SQUARE,
      WAVE_SINE,
      WAVE_TRIANGLE,
      WAVE_DECAY
   } wave_mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PHASE,
      ST_TERM,
      ST_SIDX,
      ST_SROM,
      ST_SMUL,
      ST_TMUL,
      ST_TDIV,
      ST_DMUL,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] steps;
   } div_cmd_type;

   // pi in Q30 and the Taylor denominators (2i)(2i+1)
   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam longint unsigned TAYLOR_DIV [1:19] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342,
      64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930, 64'd1056, 64'd1190,
      64'd1332, 64'd1482
   };

   // one sine table entry in signed Q(sample_bits-1), evaluated at elaboration
   function automatic logic signed [63:0] sine_entry(input int k, input int tab_bits,
                                                     input int sample_bits);
      longint unsigned kk, half, quarter, r, a, x, t, v, top;
      longint          sum;
      int              shift;
      kk      = 64'(k);
      half    = 64'd1 << (tab_bits - 1);
      quarter = 64'd1 << (tab_bits - 2);
      r       = (kk < half) ? kk : kk - half;
      a       = (r <= quarter) ? r : half - r;
      x       = (PI_Q30 * a) >> (tab_bits - 1);
      t       = x;
      sum     = $signed(x);
      for (int i = 1; i < 20; i++) begin
         t = (t * x) >> 30;
         t = (t * x) >> 30;
         t = t / TAYLOR_DIV[i];
         if (i[0]) begin
            sum = sum - $signed(t);
         end else begin
            sum = sum + $signed(t);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      shift = 30 - (sample_bits - 1);
      v     = ($unsigned(sum) + (64'd1 << (shift - 1))) >> shift;
      top   = (64'd1 << (sample_bits - 1)) - 64'd1;
      if (v > top) begin
         v = top;
      end
      return (kk < half) ? $signed(v) : -$signed(v);
   endfunction

endpackage

@@ rtl/pwg_if.sv @@
`timescale 1ns / 1ps

interface pwg_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface pwg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [pwg_pkg::SAMPLE_W-1:0] sample;
   logic                                in_delay;
   modport source (output valid, output sample, output in_delay, input ready);
   modport sink (input valid, input sample, input in_delay, output ready);
endinterface

interface pwg_csr_if;
   logic                           valid;
   logic                           ready;
   logic [pwg_pkg::CSR_IDX_W-1:0] index;
   logic [pwg_pkg::CFG_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/pwg_serial_div.sv @@
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module pwg_serial_div (
   input  logic                        clock,
   input  logic                        reset,
   input  pwg_pkg::div_cmd_type        cmd,
   input  logic [pwg_pkg::DIV_W-1:0]   divisor,
   input  logic [pwg_pkg::DIV_W-1:0]   rem_init,
   input  logic [pwg_pkg::DIV_W-1:0]   bits,
   output logic                        done,
   output logic [pwg_pkg::DIV_W-1:0]   quotient,
   output logic [pwg_pkg::DIV_W-1:0]   remainder
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [pwg_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [pwg_pkg::DIV_W-1:0]       rem_ff, rem_in;
   logic [pwg_pkg::DIV_W-1:0]       shreg_ff, shreg_in;
   logic [pwg_pkg::DIV_W-1:0]       quot_ff, quot_in;
   logic [pwg_pkg::DIV_W:0]         trial;
   logic [pwg_pkg::DIV_W:0]         diff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      shreg_in = shreg_ff;
      quot_in  = quot_ff;
      trial    = {rem_ff, shreg_ff[pwg_pkg::DIV_W-1]};
      diff     = trial - {1'b0, divisor};
      if (cmd.start) begin
         busy_in  = 1'b1;
         cnt_in   = cmd.steps;
         rem_in   = rem_init;
         shreg_in = bits;
         quot_in  = '0;
      end else if (busy_ff) begin
         // trial subtract of the next dividend bit
         if (!diff[pwg_pkg::DIV_W]) begin
            rem_in  = diff[pwg_pkg::DIV_W-1:0];
            quot_in = {quot_ff[pwg_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[pwg_pkg::DIV_W-1:0];
            quot_in = {quot_ff[pwg_pkg::DIV_W-2:0], 1'b0};
         end
         shreg_in = {shreg_ff[pwg_pkg::DIV_W-2:0], 1'b0};
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == pwg_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff   <= rem_in;
      shreg_ff <= shreg_in;
      quot_ff  <= quot_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/pwg_serial_mul.sv @@
`timescale 1ns / 1ps

// shift-add multiplier, one multiplier bit per cycle, 16-bit multiplicand
module pwg_serial_mul #(
   parameter int MUL_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [15:0]               mcand,
   input  logic [MUL_BITS-1:0]       mplier,
   output logic                      done,
   output logic [MUL_BITS+15:0]      product
);

   localparam int CNT_W = $clog2(MUL_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [15:0]           mcand_ff, mcand_in;
   logic [15:0]           hi_ff, hi_in;
   logic [MUL_BITS-1:0]   lo_ff, lo_in;
   logic [16:0]           sum;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      sum      = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : 17'd0);
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(MUL_BITS);
         mcand_in = mcand;
         hi_in    = '0;
         lo_in    = mplier;
      end else if (busy_ff) begin
         hi_in  = sum[16:1];
         lo_in  = {sum[0], lo_ff[MUL_BITS-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

@@ rtl/periodic_waveform_generator_core.sv @@
`timescale 1ns / 1ps

// Periodic waveform generator: each req transfer is one tick and yields one rsp transfer
// carrying the sample (offset plus wave term) and the in_delay flag. Items are handled one
// at a time; a new tick is taken while the previous sample still waits on rsp. A delay
// tick, a square tick, a decay-square high tick and a decay-square low tick with a zero
// factor need no serial arithmetic; a decay-square low tick runs one serial multiply; a
// sine tick runs a serial index divide, a table read and a serial multiply; and a
// triangle tick runs a serial multiply then a serial 16-bit divide. The serial multiplier
// takes max(16, SAMPLE_BITS-1) multiplier bits. The first wave tick after the delay also
// runs the phase reduction on the same serial divider. The sine table is a constant ROM
// of 2^SINE_TABLE_BITS entries with a registered read. The csr port is always ready;
// write it only while no tick is in flight.
module periodic_waveform_generator_core #(
   parameter int SINE_TABLE_BITS = pwg_pkg::SINE_TABLE_BITS_DEF,
   parameter int SAMPLE_BITS     = pwg_pkg::SAMPLE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   pwg_req_if.sink      req_ch,
   pwg_rsp_if.source    rsp_ch,
   pwg_csr_if.sink      csr_ch
);

   localparam int TAB_SIZE = 1 << SINE_TABLE_BITS;
   localparam int MUL_BITS = (SAMPLE_BITS - 1 > 16) ? SAMPLE_BITS - 1 : 16;

   // configuration
   logic [15:0]             period_ff, period_in;
   logic [15:0]             delay_ff, delay_in;
   logic [15:0]             offset_ff, offset_in;
   logic [15:0]             amp_ff, amp_in;
   logic [15:0]             duty_ff, duty_in;
   logic [15:0]             phase_ff, phase_in;
   pwg_pkg::wave_mode_type  mode_ff, mode_in;
   logic [15:0]             factor_ff, factor_in;

   // tick state
   pwg_pkg::state_type      state_ff, state_in;
   logic [15:0]             delay_cnt_ff, delay_cnt_in;
   logic                    in_wave_ff, in_wave_in;
   logic [15:0]             pos_ff, pos_in;
   logic [15:0]             decay_ff, decay_in;
   logic [16:0]             term_ff, term_in;
   logic                    res_delay_ff, res_delay_in;
   logic                    neg_ff, neg_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [16:0]             rsp_sample_ff, rsp_sample_in;
   logic                    rsp_delay_ff, rsp_delay_in;

   // serial units
   pwg_pkg::div_cmd_type    div_cmd;
   logic [15:0]             div_rem_init;
   logic [15:0]             div_bits;
   logic                    div_done;
   logic [15:0]             div_quot;
   logic [15:0]             div_rem;
   logic                    mul_start;
   logic [15:0]             mul_mcand;
   logic [MUL_BITS-1:0]     mul_mplier;
   logic                    mul_done;
   logic [MUL_BITS+15:0]    mul_prod;

   // sine rom
   logic [SAMPLE_BITS-1:0]  sine_rom [TAB_SIZE];
   logic [SAMPLE_BITS-1:0]  sine_rd_ff, sine_rd_in;
   logic [SAMPLE_BITS-1:0]  entry_mag;

   // combinational helpers
   logic [15:0]             per;
   logic [15:0]             amp_mag;
   logic [15:0]             dc;
   logic                    iw;
   logic [15:0]             p;
   logic                    tri_first;
   logic [19:0]             tri_d;
   logic [19:0]             tri_abs;
   logic [19:0]             tri_fs;
   logic                    tri_fneg;
   logic [15:0]             tri_f;
   logic [15:0]             dterm;
   logic [15:0]             dterm_mag;
   logic [31:0]             tri_sum;
   logic [16:0]             q_sine;
   logic [16:0]             q_decay;
   logic [16:0]             q_tri;
   logic [16:0]             dec_val;
   logic [17:0]             sum18;
   logic [16:0]             pos_next;

   for (genvar gk = 0; gk < TAB_SIZE; gk++) begin : g_rom
      assign sine_rom[gk] = SAMPLE_BITS'(pwg_pkg::sine_entry(gk, SINE_TABLE_BITS,
                                                             SAMPLE_BITS));
   end

   assign sine_rd_in = sine_rom[div_quot[SINE_TABLE_BITS-1:0]];
   assign entry_mag  = sine_rd_ff[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sine_rd_ff) : sine_rd_ff;

   pwg_serial_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .divisor   (per),
      .rem_init  (div_rem_init),
      .bits      (div_bits),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   pwg_serial_mul #(
      .MUL_BITS (MUL_BITS)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign csr_ch.ready = 1'b1;

   always_comb begin
      period_in = period_ff;
      delay_in  = delay_ff;
      offset_in = offset_ff;
      amp_in    = amp_ff;
      duty_in   = duty_ff;
      phase_in  = phase_ff;
      mode_in   = mode_ff;
      factor_in = factor_ff;
      if (csr_ch.valid) begin
         unique case (pwg_pkg::csr_index_type'(csr_ch.index))
            pwg_pkg::CSR_PERIOD:    period_in = csr_ch.data;
            pwg_pkg::CSR_DELAY:     delay_in  = csr_ch.data;
            pwg_pkg::CSR_OFFSET:    offset_in = csr_ch.data;
            pwg_pkg::CSR_AMPLITUDE: amp_in    = csr_ch.data;
            pwg_pkg::CSR_DUTY:      duty_in   = csr_ch.data;
            pwg_pkg::CSR_PHASE:     phase_in  = csr_ch.data;
            pwg_pkg::CSR_MODE:      mode_in   = pwg_pkg::wave_mode_type'(csr_ch.data[1:0]);
            pwg_pkg::CSR_DECAY:     factor_in = csr_ch.data;
         endcase
      end
   end

   // shared arithmetic for the tick sequencer
   always_comb begin
      per       = (period_ff == 16'd0) ? 16'd1 : period_ff;
      amp_mag   = amp_ff[15] ? 16'(-amp_ff) : amp_ff;
      dc        = req_ch.restart ? 16'd0 : delay_cnt_ff;
      iw        = req_ch.restart ? 1'b0 : in_wave_ff;
      p         = (pos_ff >= per) ? 16'd0 : pos_ff;
      tri_first = p < {1'b0, per[15:1]};
      if (tri_first) begin
         tri_d = {2'b00, p, 2'b00} - {4'b0000, per};
      end else begin
         tri_d = {2'b00, p, 2'b00} - ({4'b0000, per} + {3'b000, per, 1'b0});
      end
      tri_abs   = tri_d[19] ? 20'(-tri_d) : tri_d;
      // odd period at its midpoint gives a slightly negative factor
      tri_fs    = {4'b0000, per} - tri_abs;
      tri_fneg  = tri_fs[19];
      tri_f     = tri_fneg ? 16'(-tri_fs) : tri_fs[15:0];
      dterm     = (p == duty_ff) ? amp_ff : decay_ff;
      dterm_mag = dterm[15] ? 16'(-dterm) : dterm;
      tri_sum   = mul_prod[31:0] + {17'd0, per[15:1]};
      q_sine    = {1'b0, mul_prod[SAMPLE_BITS-1 +: 16]} + {16'd0, mul_prod[SAMPLE_BITS-2]};
      q_decay   = {1'b0, mul_prod[31:16]} + {16'd0, mul_prod[15]};
      // a period of one divides by one and may need the 17th bit
      q_tri     = (per == 16'd1) ? tri_sum[16:0] : {1'b0, div_quot};
      dec_val   = neg_ff ? 17'(-q_decay) : q_decay;
      sum18     = {{2{offset_ff[15]}}, offset_ff} + {term_ff[16], term_ff};
      pos_next  = {1'b0, pos_ff} + 17'd1;
   end

   always_comb begin
      state_in      = state_ff;
      delay_cnt_in  = delay_cnt_ff;
      in_wave_in    = in_wave_ff;
      pos_in        = pos_ff;
      decay_in      = decay_ff;
      term_in       = term_ff;
      res_delay_in  = res_delay_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_delay_in  = rsp_delay_ff;
      div_cmd       = '0;
      div_rem_init  = '0;
      div_bits      = '0;
      mul_start     = 1'b0;
      mul_mcand     = amp_mag;
      mul_mplier    = '0;
      req_ch.ready  = (state_ff == pwg_pkg::ST_IDLE);

      unique case (state_ff)
         pwg_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               delay_cnt_in = dc;
               in_wave_in   = iw;
               res_delay_in = 1'b0;
               if (req_ch.restart) begin
                  decay_in = 16'd0;
               end
               if (!iw && dc < delay_ff) begin
                  delay_cnt_in = dc + 16'd1;
                  term_in      = '0;
                  res_delay_in = 1'b1;
                  state_in     = pwg_pkg::ST_FIN;
               end else if (!iw) begin
                  // wave start: reduce phase modulo the period
                  in_wave_in    = 1'b1;
                  decay_in      = 16'd0;
                  div_cmd.start = 1'b1;
                  div_cmd.steps = pwg_pkg::DIV_CNT_W'(pwg_pkg::DIV_W);
                  div_bits      = phase_ff;
                  state_in      = pwg_pkg::ST_PHASE;
               end else begin
                  state_in = pwg_pkg::ST_TERM;
               end
            end
         end
         pwg_pkg::ST_PHASE: begin
            if (div_done) begin
               pos_in   = div_rem;
               state_in = pwg_pkg::ST_TERM;
            end
         end
         pwg_pkg::ST_TERM: begin
            pos_in = p;
            unique case (mode_ff)
               pwg_pkg::WAVE_SQUARE: begin
                  term_in  = (p < duty_ff) ? {amp_ff[15], amp_ff} : 17'd0;
                  state_in = pwg_pkg::ST_FIN;
               end
               pwg_pkg::WAVE_SINE: begin
                  // table index = (p << SINE_TABLE_BITS) / period
                  div_cmd.start = 1'b1;
                  div_cmd.steps = pwg_pkg::DIV_CNT_W'(SINE_TABLE_BITS);
                  div_rem_init  = p;
                  state_in      = pwg_pkg::ST_SIDX;
               end
               pwg_pkg::WAVE_TRIANGLE: begin
                  mul_start  = 1'b1;
                  mul_mplier = MUL_BITS'(tri_f);
                  neg_in     = amp_ff[15] ^ ~tri_first ^ tri_fneg;
                  state_in   = pwg_pkg::ST_TMUL;
               end
               pwg_pkg::WAVE_DECAY: begin
                  if (p < duty_ff) begin
                     term_in  = {amp_ff[15], amp_ff};
                     state_in = pwg_pkg::ST_FIN;
                  end else if (factor_ff == 16'd0) begin
                     term_in  = '0;
                     state_in = pwg_pkg::ST_FIN;
                  end else begin
                     term_in    = {dterm[15], dterm};
                     mul_start  = 1'b1;
                     mul_mcand  = dterm_mag;
                     mul_mplier = MUL_BITS'(factor_ff);
                     neg_in     = dterm[15];
                     state_in   = pwg_pkg::ST_DMUL;
                  end
               end
            endcase
         end
         pwg_pkg::ST_SIDX: begin
            if (div_done) begin
               state_in = pwg_pkg::ST_SROM;
            end
         end
         pwg_pkg::ST_SROM: begin
            mul_start  = 1'b1;
            mul_mplier = MUL_BITS'(entry_mag[SAMPLE_BITS-2:0]);
            neg_in     = amp_ff[15] ^ sine_rd_ff[SAMPLE_BITS-1];
            state_in   = pwg_pkg::ST_SMUL;
         end
         pwg_pkg::ST_SMUL: begin
            if (mul_done) begin
               term_in  = neg_ff ? 17'(-q_sine) : q_sine;
               state_in = pwg_pkg::ST_FIN;
            end
         end
         pwg_pkg::ST_TMUL: begin
            if (mul_done) begin
               // rounded divide: top half is below the period except for a period of
               // one, whose quotient is taken from the product directly
               div_cmd.start = 1'b1;
               div_cmd.steps = pwg_pkg::DIV_CNT_W'(pwg_pkg::DIV_W);
               div_rem_init  = tri_sum[31:16];
               div_bits      = tri_sum[15:0];
               state_in      = pwg_pkg::ST_TDIV;
            end
         end
         pwg_pkg::ST_TDIV: begin
            if (div_done) begin
               term_in  = neg_ff ? 17'(-q_tri) : q_tri;
               state_in = pwg_pkg::ST_FIN;
            end
         end
         pwg_pkg::ST_DMUL: begin
            if (mul_done) begin
               decay_in = dec_val[15:0];
               state_in = pwg_pkg::ST_FIN;
            end
         end
         pwg_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sum18[16:0];
               rsp_delay_in  = res_delay_ff;
               if (!res_delay_ff) begin
                  pos_in = (pos_next >= {1'b0, per}) ? 16'd0 : pos_next[15:0];
               end
               state_in = pwg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pwg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= pwg_pkg::PERIOD_RST;
         delay_ff     <= pwg_pkg::DELAY_RST;
         offset_ff    <= pwg_pkg::OFFSET_RST;
         amp_ff       <= pwg_pkg::AMP_RST;
         duty_ff      <= pwg_pkg::DUTY_RST;
         phase_ff     <= pwg_pkg::PHASE_RST;
         mode_ff      <= pwg_pkg::WAVE_SQUARE;
         factor_ff    <= pwg_pkg::DECAY_RST;
         state_ff     <= pwg_pkg::ST_IDLE;
         delay_cnt_ff <= '0;
         in_wave_ff   <= 1'b0;
         pos_ff       <= '0;
         decay_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         delay_ff     <= delay_in;
         offset_ff    <= offset_in;
         amp_ff       <= amp_in;
         duty_ff      <= duty_in;
         phase_ff     <= phase_in;
         mode_ff      <= mode_in;
         factor_ff    <= factor_in;
         state_ff     <= state_in;
         delay_cnt_ff <= delay_cnt_in;
         in_wave_ff   <= in_wave_in;
         pos_ff       <= pos_in;
         decay_ff     <= decay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      term_ff       <= term_in;
      res_delay_ff  <= res_delay_in;
      neg_ff        <= neg_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_delay_ff  <= rsp_delay_in;
      sine_rd_ff    <= sine_rd_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.sample   = rsp_sample_ff;
   assign rsp_ch.in_delay = rsp_delay_ff;

endmodule
